// ===== sv/sme_pkg.sv =====
// Package: widths, depths, opcode and status codes of the stack machine executor.
package sme_pkg;
  localparam int WordWidth  = 64;
  localparam int AddrWidth  = 16;
  localparam int DataDepth  = 1024;
  localparam int CallDepth  = 256;
  localparam int HeapWords  = 4096;
  localparam int DataAw     = $clog2(DataDepth);
  localparam int CallAw     = $clog2(CallDepth);
  localparam int HeapAw     = $clog2(HeapWords);
  localparam int DataCw     = $clog2(DataDepth + 1);
  localparam int CallCw     = $clog2(CallDepth + 1);
  localparam logic [WordWidth-1:0] MaxCharCode = WordWidth'(64'h10FFFF);

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [AddrWidth-1:0] addr_t;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_DUP = 5'd1, OP_SWAP = 5'd2, OP_DROP = 5'd3, OP_COPY = 5'd4,
    OP_SLIDE = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_DIV = 5'd9,
    OP_MOD = 5'd10, OP_STORE = 5'd11, OP_LOAD = 5'd12, OP_OUTCHAR = 5'd13,
    OP_OUTINT = 5'd14, OP_INCHAR = 5'd15, OP_ININT = 5'd16, OP_MARK = 5'd17,
    OP_CALL = 5'd18, OP_GOTO = 5'd19, OP_IFZERO = 5'd20, OP_IFNEG = 5'd21,
    OP_RET = 5'd22, OP_EXIT = 5'd23
  } op_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_FEW = 4'd1, ST_OVF = 4'd2, ST_COPY = 4'd3, ST_HEAP = 4'd4,
    ST_CHAR = 4'd5, ST_COVF = 4'd6, ST_CUNF = 4'd7, ST_UNK = 4'd8, ST_DIV0 = 4'd9,
    ST_RFAIL = 4'd10, ST_RCHAR = 4'd11
  } status_t;

  localparam logic [1:0] FL_SEQ = 2'd0, FL_JUMP = 2'd1, FL_RET = 2'd2, FL_HALT = 2'd3;
  localparam logic [1:0] OK_NONE = 2'd0, OK_CHAR = 2'd1, OK_INT = 2'd2;
  localparam logic [1:0] RE_OK = 2'd0, RE_BADCHAR = 2'd2;

  // divider request and reply
  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
    word_t rem;
  } div_rsp_t;
endpackage

// ===== sv/stack_machine_executor_core.sv =====
// Top level: sequencer around the data stack, call stack and heap memories.
//
//  channel | ports                                   | handshake
//  in      | in_mode .. in_read_error                | start & !busy
//  out     | out_status .. out_output_value          | out_valid, one cycle
//
// A new item is accepted only once the last is through (two stack reads, execute, write
// back); the result strobe comes in the cycle where busy drops, but swap stays busy
// through a settle state. Load adds a heap read, mul three 32x32 partial products,
// div/mod the bit-serial divider unless dividing by zero. Each memory has one read and
// one write port. After reset a clearing pass writes zero to the 4096 heap words, one a
// cycle, with busy high; then the block is ready. Results cannot be stalled.
module stack_machine_executor_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [4:0]                   in_mode,
  input  logic signed [63:0]           in_immediate,
  input  logic [15:0]                  in_target_address,
  input  logic [15:0]                  in_return_address,
  input  logic signed [63:0]           in_read_value,
  input  logic [1:0]                   in_read_error,
  output logic                         out_valid,
  output logic [3:0]                   out_status,
  output logic [1:0]                   out_flow_action,
  output logic [15:0]                  out_next_address,
  output logic [1:0]                   out_output_kind,
  output logic signed [63:0]           out_output_value
);
  import sme_pkg::*;
  localparam int HalfW = WordWidth / 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_HEAP, S_MUL, S_DIV, S_DIVW, S_WR, S_SETTLE
  } state_t;

  // memories
  word_t dmem [DataDepth];
  addr_t cmem [CallDepth];
  word_t hmem [HeapWords];

  state_t state_r;
  logic [DataCw-1:0] dcnt_r;
  logic [CallCw-1:0] ccnt_r;
  logic [HeapAw-1:0] clr_r;
  logic [4:0]  mode_r;
  word_t imm_r, rval_r;
  addr_t tgt_r, ret_r;
  logic [1:0] rerr_r;
  word_t a_r, b_r, mul_r;
  logic [1:0] mcnt_r;
  logic [DataAw-1:0] draddr_r;
  word_t drdata_r, hrdata_r;
  addr_t crdata_r;
  logic [HeapAw-1:0] hraddr_r;
  // result registers
  logic valid_r;
  logic [3:0] st_r;
  logic [1:0] fl_r, kind_r;
  addr_t nxt_r;
  word_t oval_r;

  // write requests (registered)
  logic dwe_r; logic [DataAw-1:0] dwa_r; word_t dwd_r;
  logic dwe2_r; logic [DataAw-1:0] dwa2_r; word_t dwd2_r;
  logic hwe_r; logic [HeapAw-1:0] hwa_r; word_t hwd_r;
  logic cwe_r; logic [CallAw-1:0] cwa_r; addr_t cwd_r;

  div_req_t dreq;
  div_rsp_t drsp;
  sme_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // synchronous memories with registered reads
  always_ff @(posedge clk) begin
    drdata_r <= dmem[draddr_r];
    hrdata_r <= hmem[hraddr_r];
    crdata_r <= cmem[ccnt_r[CallAw-1:0] - CallAw'(1)];
    if (dwe_r) dmem[dwa_r] <= dwd_r;
    if (hwe_r) hmem[hwa_r] <= hwd_r;
    if (cwe_r) cmem[cwa_r] <= cwd_r;
  end

  // multiplier halves: low x low, low x high, high x low
  logic [HalfW-1:0] mul_x, mul_y;
  word_t mul_p;
  assign mul_x = (mcnt_r == 2'd2) ? a_r[WordWidth-1:HalfW] : a_r[HalfW-1:0];
  assign mul_y = (mcnt_r == 2'd1) ? b_r[WordWidth-1:HalfW] : b_r[HalfW-1:0];
  assign mul_p = mul_x * mul_y;

  // helper values for the execute step
  logic [DataCw-1:0] n;
  logic imm_neg, few1, few2, full, heap_ok_a, heap_ok_b;
  logic [DataCw-1:0] slide_k;
  logic copy_bad;
  assign n        = dcnt_r;
  assign imm_neg  = imm_r[WordWidth-1];
  assign few1     = (n == '0);
  assign few2     = (n < DataCw'(2));
  assign full     = (n >= DataCw'(DataDepth));
  assign copy_bad = imm_neg || (imm_r >= WordWidth'(n));
  assign slide_k  = (imm_neg || imm_r > WordWidth'(n - 1'b1)) ? n - 1'b1
                                                              : imm_r[DataCw-1:0];
  assign heap_ok_a = !a_r[WordWidth-1] && a_r < WordWidth'(HeapWords);
  assign heap_ok_b = !b_r[WordWidth-1] && b_r < WordWidth'(HeapWords);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      dcnt_r  <= '0;
      ccnt_r  <= '0;
      valid_r <= 1'b0;
      dwe_r <= 1'b0; dwe2_r <= 1'b0; hwe_r <= 1'b0; cwe_r <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      hwe_r <= 1'b0; cwe_r <= 1'b0; dreq.start <= 1'b0;
      // second stack write lands in the cycle after the first
      dwe_r <= dwe2_r; dwa_r <= dwa2_r; dwd_r <= dwd2_r; dwe2_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          hwe_r <= 1'b1; hwa_r <= clr_r; hwd_r <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == HeapAw'(HeapWords - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          mode_r <= in_mode; imm_r <= in_immediate; tgt_r <= in_target_address;
          ret_r <= in_return_address; rval_r <= in_read_value; rerr_r <= in_read_error;
          draddr_r <= DataAw'(n - 1'b1);
          state_r <= S_RD1;
        end
        S_RD1: begin
          // second read: copy source or element below top
          if (mode_r == OP_COPY) draddr_r <= DataAw'(n - 1'b1 - DataCw'(imm_r));
          else draddr_r <= DataAw'(n - DataCw'(2));
          state_r <= S_RD2;
        end
        S_RD2: begin
          b_r <= drdata_r;   // top
          hraddr_r <= drdata_r[HeapAw-1:0];
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          a_r <= drdata_r;   // second, or copy source
          mcnt_r <= '0;
          state_r <= S_WR;
          if (mode_r == OP_MUL) state_r <= S_MUL;
          if (mode_r == OP_DIV || mode_r == OP_MOD) state_r <= S_DIV;
          if (mode_r == OP_LOAD) state_r <= S_HEAP;
        end
        S_HEAP: state_r <= S_WR;
        S_MUL: begin
          // one partial product a cycle, low word only
          if (mcnt_r == 2'd0) mul_r <= mul_p;
          else mul_r <= mul_r + {mul_p[HalfW-1:0], {HalfW{1'b0}}};
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 2'd2) state_r <= S_WR;
        end
        S_DIV: begin
          if (!few2 && b_r != '0) begin
            dreq.start <= 1'b1; dreq.num <= a_r; dreq.den <= b_r;
            state_r <= S_DIVW;
          end else state_r <= S_WR;
        end
        S_DIVW: if (drsp.done) state_r <= S_WR;
        S_SETTLE: state_r <= S_IDLE;
        S_WR: begin
          logic [3:0] st;
          logic [1:0] fl, kd;
          addr_t nx;
          word_t ov;
          st = ST_OK; fl = FL_SEQ; kd = OK_NONE; nx = '0; ov = '0;
          state_r <= S_IDLE;
          valid_r <= 1'b1;
          case (mode_r)
            OP_PUSH: if (full) st = ST_OVF;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n); dwd_r <= imm_r; dcnt_r <= n + 1'b1;
              end
            OP_DUP: if (few1) st = ST_FEW; else if (full) st = ST_OVF;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n); dwd_r <= b_r; dcnt_r <= n + 1'b1;
              end
            OP_SWAP: if (few2) st = ST_FEW;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n - 1'b1); dwd_r <= a_r;
                dwe2_r <= 1'b1; dwa2_r <= DataAw'(n - DataCw'(2)); dwd2_r <= b_r;
                state_r <= S_SETTLE;   // let the second write land
                valid_r <= 1'b1;
              end
            OP_DROP: if (few1) st = ST_FEW; else dcnt_r <= n - 1'b1;
            OP_COPY: if (copy_bad) st = ST_COPY; else if (full) st = ST_OVF;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n); dwd_r <= a_r; dcnt_r <= n + 1'b1;
              end
            OP_SLIDE: if (few1) st = ST_FEW;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n - 1'b1 - slide_k); dwd_r <= b_r;
                dcnt_r <= n - slide_k;
              end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (few2) st = ST_FEW;
              else if ((mode_r == OP_DIV || mode_r == OP_MOD) && b_r == '0) st = ST_DIV0;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n - DataCw'(2)); dcnt_r <= n - 1'b1;
                case (mode_r)
                  OP_ADD:  dwd_r <= a_r + b_r;
                  OP_SUB:  dwd_r <= a_r - b_r;
                  OP_MUL:  dwd_r <= mul_r;
                  OP_DIV:  dwd_r <= drsp.quo;
                  default: dwd_r <= drsp.rem;
                endcase
              end
            end
            OP_STORE: if (few2) st = ST_FEW; else if (!heap_ok_a) st = ST_HEAP;
              else begin
                hwe_r <= 1'b1; hwa_r <= a_r[HeapAw-1:0]; hwd_r <= b_r;
                dcnt_r <= n - DataCw'(2);
              end
            OP_LOAD: if (few1) st = ST_FEW; else if (!heap_ok_b) st = ST_HEAP;
              else begin
                dwe_r <= 1'b1; dwa_r <= DataAw'(n - 1'b1); dwd_r <= hrdata_r;
              end
            OP_OUTCHAR: if (few1) st = ST_FEW;
              else if (b_r[WordWidth-1] || b_r > MaxCharCode) st = ST_CHAR;
              else begin kd = OK_CHAR; ov = b_r; dcnt_r <= n - 1'b1; end
            OP_OUTINT: if (few1) st = ST_FEW;
              else begin kd = OK_INT; ov = b_r; dcnt_r <= n - 1'b1; end
            OP_INCHAR, OP_ININT: if (few1) st = ST_FEW;
              else if (!heap_ok_b) st = ST_HEAP;
              else if (rerr_r == RE_BADCHAR) st = (mode_r == OP_INCHAR) ? ST_CHAR : ST_RCHAR;
              else if (rerr_r != RE_OK) st = ST_RFAIL;
              else begin
                hwe_r <= 1'b1; hwa_r <= b_r[HeapAw-1:0]; hwd_r <= rval_r;
                dcnt_r <= n - 1'b1;
              end
            OP_MARK: ;
            OP_CALL: if (ccnt_r >= CallCw'(CallDepth)) st = ST_COVF;
              else begin
                cwe_r <= 1'b1; cwa_r <= CallAw'(ccnt_r); cwd_r <= ret_r;
                ccnt_r <= ccnt_r + 1'b1; fl = FL_JUMP; nx = tgt_r;
              end
            OP_GOTO: begin fl = FL_JUMP; nx = tgt_r; end
            OP_IFZERO, OP_IFNEG: if (few1) st = ST_FEW;
              else begin
                dcnt_r <= n - 1'b1;
                if ((mode_r == OP_IFZERO) ? (b_r == '0) : b_r[WordWidth-1]) begin
                  fl = FL_JUMP; nx = tgt_r;
                end
              end
            OP_RET: if (ccnt_r == '0) st = ST_CUNF;
              else begin ccnt_r <= ccnt_r - 1'b1; fl = FL_RET; nx = crdata_r; end
            OP_EXIT: fl = FL_HALT;
            default: st = ST_UNK;
          endcase
          if (st != ST_OK) begin fl = FL_HALT; nx = '0; kd = OK_NONE; ov = '0; end
          st_r <= st; fl_r <= fl; nxt_r <= nx; kind_r <= kd; oval_r <= ov;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = valid_r;
  assign out_status       = st_r;
  assign out_flow_action  = fl_r;
  assign out_next_address = nxt_r;
  assign out_output_kind  = kind_r;
  assign out_output_value = oval_r;

  // checks
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DataCw'(DataDepth)) else $error("data count overrun");
  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_flow_action == FL_HALT && out_output_kind == OK_NONE)
    else $error("error without halt");
  a_one_res: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("result too early");
endmodule

// ===== sv/sme_divider.sv =====
// Signed truncating divider, restoring, one quotient bit per cycle.
module sme_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::div_req_t req,
  output sme_pkg::div_rsp_t rsp
);
  import sme_pkg::*;
  localparam int CntW = $clog2(WordWidth + 1);

  logic            busy_r;
  logic [CntW-1:0] cnt_r;
  word_t           q_r, d_r;
  logic [WordWidth:0] rem_r;
  logic            negq_r, negr_r, done_r;
  logic [WordWidth:0] trial;

  assign trial = {rem_r[WordWidth-1:0], q_r[WordWidth-1]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(WordWidth);
        q_r    <= req.num[WordWidth-1] ? -req.num : req.num;
        d_r    <= req.den[WordWidth-1] ? -req.den : req.den;
        rem_r  <= '0;
        negq_r <= req.num[WordWidth-1] ^ req.den[WordWidth-1];
        negr_r <= req.num[WordWidth-1];
      end else if (busy_r) begin
        // shift one dividend bit in, subtract when it fits
        if (!trial[WordWidth]) rem_r <= trial;
        else rem_r <= {rem_r[WordWidth-1:0], q_r[WordWidth-1]};
        q_r   <= {q_r[WordWidth-2:0], ~trial[WordWidth]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = negq_r ? -q_r : q_r;
  assign rsp.rem  = negr_r ? -rem_r[WordWidth-1:0] : rem_r[WordWidth-1:0];
endmodule

// ===== sim/sme_checker.sv =====
// Checker: predicts each executed instruction and compares the reported results.
module sme_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [4:0]         in_mode,
  input  logic signed [63:0] in_immediate,
  input  logic [15:0]        in_target_address,
  input  logic [15:0]        in_return_address,
  input  logic signed [63:0] in_read_value,
  input  logic [1:0]         in_read_error,
  input  logic               out_valid,
  input  logic [3:0]         out_status,
  input  logic [1:0]         out_flow_action,
  input  logic [15:0]        out_next_address,
  input  logic [1:0]         out_output_kind,
  input  logic signed [63:0] out_output_value,
  output int                 fail_count,
  output int                 pending,
  output int                 depth_now,
  output int                 calls_now
);
  import sme_pkg::*;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  flow;
    logic [15:0] next;
    logic [1:0]  kind;
    word_t       value;
  } outcome_t;

  word_t    stack_mem [DataDepth];
  addr_t    ret_mem [CallDepth];
  word_t    heap_mem [HeapWords];
  int       sp;
  int       csp;
  outcome_t awaited [$];

  assign pending   = awaited.size();
  assign depth_now = sp;
  assign calls_now = csp;

  function automatic logic heap_addr_ok(word_t a);
    return !a[WordWidth-1] && a < HeapWords;
  endfunction

  // execute one instruction on the shadow state
  function automatic outcome_t execute(logic [4:0] mode, word_t imm, addr_t tgt, addr_t ret,
                                       word_t rval, logic [1:0] rerr);
    outcome_t o;
    word_t    a, b, r, q, ua, ub, top;
    int       n, k;
    o = '0;
    n = sp;
    case (mode)
      OP_PUSH: begin
        if (n >= DataDepth) o.status = ST_OVF;
        else begin stack_mem[n] = imm; sp = n + 1; end
      end
      OP_DUP: begin
        if (n < 1) o.status = ST_FEW;
        else if (n >= DataDepth) o.status = ST_OVF;
        else begin stack_mem[n] = stack_mem[n-1]; sp = n + 1; end
      end
      OP_SWAP: begin
        if (n < 2) o.status = ST_FEW;
        else begin
          a = stack_mem[n-1]; stack_mem[n-1] = stack_mem[n-2]; stack_mem[n-2] = a;
        end
      end
      OP_DROP: begin
        if (n < 1) o.status = ST_FEW;
        else sp = n - 1;
      end
      OP_COPY: begin
        if (imm[63] || imm >= n) o.status = ST_COPY;
        else if (n >= DataDepth) o.status = ST_OVF;
        else begin stack_mem[n] = stack_mem[n-1-int'(imm)]; sp = n + 1; end
      end
      OP_SLIDE: begin
        if (n < 1) o.status = ST_FEW;
        else begin
          k = (imm[63] || imm > n - 1) ? n - 1 : int'(imm);
          stack_mem[n-1-k] = stack_mem[n-1];
          sp = n - k;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (n < 2) o.status = ST_FEW;
        else begin
          a = stack_mem[n-2]; b = stack_mem[n-1];
          r = '0;
          if (mode == OP_ADD) r = a + b;
          else if (mode == OP_SUB) r = a - b;
          else if (mode == OP_MUL) r = a * b;
          else if (b == '0) o.status = ST_DIV0;
          else begin
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = ua / ub;
            if (a[63] != b[63]) q = -q;
            r = ua % ub;
            if (a[63]) r = -r;
            if (mode == OP_DIV) r = q;
          end
          if (o.status == ST_OK) begin stack_mem[n-2] = r; sp = n - 1; end
        end
      end
      OP_STORE: begin
        if (n < 2) o.status = ST_FEW;
        else if (!heap_addr_ok(stack_mem[n-2])) o.status = ST_HEAP;
        else begin heap_mem[stack_mem[n-2][HeapAw-1:0]] = stack_mem[n-1]; sp = n - 2; end
      end
      OP_LOAD: begin
        if (n < 1) o.status = ST_FEW;
        else if (!heap_addr_ok(stack_mem[n-1])) o.status = ST_HEAP;
        else stack_mem[n-1] = heap_mem[stack_mem[n-1][HeapAw-1:0]];
      end
      OP_OUTCHAR: begin
        if (n < 1) o.status = ST_FEW;
        else begin
          top = stack_mem[n-1];
          if (top[63] || top > MaxCharCode) o.status = ST_CHAR;
          else begin o.kind = OK_CHAR; o.value = top; sp = n - 1; end
        end
      end
      OP_OUTINT: begin
        if (n < 1) o.status = ST_FEW;
        else begin o.kind = OK_INT; o.value = stack_mem[n-1]; sp = n - 1; end
      end
      OP_INCHAR, OP_ININT: begin
        if (n < 1) o.status = ST_FEW;
        else if (!heap_addr_ok(stack_mem[n-1])) o.status = ST_HEAP;
        else if (rerr == RE_BADCHAR) o.status = (mode == OP_INCHAR) ? ST_CHAR : ST_RCHAR;
        else if (rerr != RE_OK) o.status = ST_RFAIL;
        else begin heap_mem[stack_mem[n-1][HeapAw-1:0]] = rval; sp = n - 1; end
      end
      OP_MARK: ;
      OP_CALL: begin
        if (csp >= CallDepth) o.status = ST_COVF;
        else begin
          ret_mem[csp] = ret; csp++;
          o.flow = FL_JUMP; o.next = tgt;
        end
      end
      OP_GOTO: begin o.flow = FL_JUMP; o.next = tgt; end
      OP_IFZERO, OP_IFNEG: begin
        if (n < 1) o.status = ST_FEW;
        else begin
          top = stack_mem[n-1]; sp = n - 1;
          if ((mode == OP_IFZERO) ? (top == '0) : top[63]) begin
            o.flow = FL_JUMP; o.next = tgt;
          end
        end
      end
      OP_RET: begin
        if (csp < 1) o.status = ST_CUNF;
        else begin csp--; o.flow = FL_RET; o.next = ret_mem[csp]; end
      end
      OP_EXIT: o.flow = FL_HALT;
      default: o.status = ST_UNK;
    endcase
    if (o.status != ST_OK) begin
      o.flow = FL_HALT; o.next = '0; o.kind = OK_NONE; o.value = '0;
    end
    return o;
  endfunction

  // predict on acceptance, compare on each strobe
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst_n) begin
      sp = 0;
      csp = 0;
      fail_count <= 0;
      awaited.delete();
      for (int i = 0; i < HeapWords; i++) heap_mem[i] = '0;
    end else begin
      if (start && !busy)
        awaited.push_back(execute(in_mode, in_immediate, in_target_address,
                                  in_return_address, in_read_value, in_read_error));
      if (out_valid) begin
        got = '{out_status, out_flow_action, out_next_address, out_output_kind,
                out_output_value};
        if (awaited.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d fl=%0d nx=%h k=%0d v=%h", $time,
                     want.status, want.flow, want.next, want.kind, want.value);
            $display("%0t:          actual   st=%0d fl=%0d nx=%h k=%0d v=%h", $time,
                     got.status, got.flow, got.next, got.kind, got.value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/stack_machine_executor_core_tb.sv =====
// Testbench top: drives instruction items into the executor and gives the verdict.
module stack_machine_executor_core_tb;
  import sme_pkg::*;

  localparam int CycleLimit = 900000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [4:0]         in_mode;
  logic signed [63:0] in_immediate;
  logic [15:0]        in_target_address;
  logic [15:0]        in_return_address;
  logic signed [63:0] in_read_value;
  logic [1:0]         in_read_error;
  logic               out_valid;
  logic [3:0]         out_status;
  logic [1:0]         out_flow_action;
  logic [15:0]        out_next_address;
  logic [1:0]         out_output_kind;
  logic signed [63:0] out_output_value;
  int                 fail_count;
  int                 pending;
  int                 depth_now;
  int                 calls_now;
  int                 cycles;

  stack_machine_executor_core u_top (.*);

  sme_checker u_chk (.*);

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // value with bias towards edges and small heap addresses
  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return '0;
      4: return word_t'($urandom_range(0, HeapWords + 3));
      5: return word_t'($urandom_range(0, 32'h11_0005));
      6: return -word_t'($urandom_range(0, 20));
      default: return rand_word();
    endcase
  endfunction

  // drop start only when a real gap follows
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // present one item and hold it until accepted
  task automatic issue(logic [4:0] mode, word_t imm, logic [15:0] tgt, logic [15:0] ret,
                       word_t rval, logic [1:0] rerr);
    start             <= 1'b1;
    in_mode           <= mode;
    in_immediate      <= imm;
    in_target_address <= tgt;
    in_return_address <= ret;
    in_read_value     <= rval;
    in_read_error     <= rerr;
    do @(posedge clk); while (busy);
    idle_gap();
  endtask

  task automatic issue_random();
    logic [4:0] mode;
    word_t      imm;
    int         r;
    r = $urandom_range(0, 99);
    // keep the stack well fed, sometimes deep
    if (r < 25 || depth_now < 2) mode = OP_PUSH;
    else if (r < 30) mode = 5'($urandom_range(24, 31));
    else mode = 5'($urandom_range(1, 23));
    if (mode == OP_CALL && calls_now == 0 && $urandom_range(0, 1)) mode = OP_CALL;
    if (mode == OP_RET && calls_now == 0 && $urandom_range(0, 3) != 0) mode = OP_CALL;
    imm = pick_value();
    if ((mode == OP_COPY || mode == OP_SLIDE) && $urandom_range(0, 3) != 0)
      imm = word_t'($urandom_range(0, depth_now + 1));
    issue(mode, imm, 16'($urandom), 16'($urandom), pick_value(),
          ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : RE_OK);
  endtask

  initial begin
    word_t ones;
    ones = '1;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_mode           = '0;
    in_immediate      = '0;
    in_target_address = '0;
    in_return_address = '0;
    in_read_value     = '0;
    in_read_error     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: underflow cases, edges, an unknown opcode
    issue(OP_DROP, '0, '0, '0, '0, RE_OK);
    issue(OP_RET, '0, '0, '0, '0, RE_OK);
    issue(OP_COPY, '0, '0, '0, '0, RE_OK);
    issue(OP_PUSH, 64'h8000_0000_0000_0000, '0, '0, '0, RE_OK);
    issue(OP_PUSH, ones, '0, '0, '0, RE_OK);
    issue(OP_DIV, '0, '0, '0, '0, RE_OK);
    issue(OP_PUSH, '0, '0, '0, '0, RE_OK);
    issue(OP_MOD, '0, '0, '0, '0, RE_OK);
    issue(OP_PUSH, 64'h7fff_ffff_ffff_ffff, '0, '0, '0, RE_OK);
    issue(OP_COPY, ones, '0, '0, '0, RE_OK);
    issue(OP_COPY, 64'd1, '0, '0, '0, RE_OK);
    issue(OP_SLIDE, ones, '0, '0, '0, RE_OK);
    issue(OP_PUSH, 64'h11_0000, '0, '0, '0, RE_OK);
    issue(OP_OUTCHAR, '0, '0, '0, '0, RE_OK);
    issue(OP_PUSH, 64'd4095, '0, '0, '0, RE_OK);
    issue(OP_ININT, '0, '0, '0, ones, RE_BADCHAR);
    issue(OP_INCHAR, '0, '0, '0, ones, 2'd3);
    issue(OP_ININT, '0, '0, '0, 64'h8000_0000_0000_0001, RE_OK);
    issue(OP_CALL, '0, 16'hffff, 16'hffff, '0, RE_OK);
    issue(OP_RET, '0, '0, '0, '0, RE_OK);
    issue(OP_PUSH, 64'd4096, '0, '0, '0, RE_OK);
    issue(OP_LOAD, '0, '0, '0, '0, RE_OK);
    issue(OP_MARK, '0, '0, '0, '0, RE_OK);
    issue(OP_EXIT, '0, '0, '0, '0, RE_OK);
    issue(5'd31, '0, '0, '0, '0, RE_OK);

    for (int i = 0; i < 120; i++) begin
      // drain once midway
      if (i == 60) begin
        start <= 1'b0;
        wait (pending == 0);
      end
      // a burst of calls past the call-stack depth, once
      if (i == 90) begin
        for (int j = 0; j < CallDepth + 1; j++)
          issue(OP_CALL, '0, 16'($urandom), 16'($urandom), '0, RE_OK);
      end
      issue_random();
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
